>>> rtl/pmtdpd_pkg.sv
package pmtdpd_pkg;

  // Fixed field widths of the sample, result and register ports.
  localparam int unsigned ADC_BITS   = 14;
  localparam int unsigned ADC_MAX    = (1 << ADC_BITS) - 1;
  localparam int unsigned THR_W      = 14;
  localparam int unsigned NSPS_W     = 7;
  localparam int unsigned LATE_W     = 10;
  localparam int unsigned HEIGHT_W   = 15;
  localparam int unsigned PEAK_W     = 7;
  localparam int unsigned COUNT_W    = 32;
  localparam int unsigned CFG_DATA_W = 14;
  localparam int unsigned CFG_IDX_W  = 2;

  // Number of baseline windows; the first and the last are candidates.
  localparam int unsigned NUM_WIN = 4;

  // Defaults for the top-level parameters.
  localparam int unsigned MAX_SAMPLES_DEF = 128;
  localparam int unsigned WINDOW_LEN_DEF  = 25;

  // Register reset values.
  localparam logic [THR_W-1:0]  THRESHOLD_RST = THR_W'(10);
  localparam logic [NSPS_W-1:0] NSPS_RST      = NSPS_W'(2);
  localparam logic [LATE_W-1:0] LATE_RST      = LATE_W'(60);

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_THRESHOLD     = 2'd0,
    CFG_NS_PER_SAMPLE = 2'd1,
    CFG_LATE_PEAK     = 2'd2
  } cfg_index_e;

endpackage

>>> rtl/pmt_dark_pulse_discriminator.sv
// Dark-pulse discriminator for photomultiplier waveforms. Samples of a waveform arrive one
// per request with a mark on the final one; the block sums four windows of WINDOW_LEN samples,
// tracks the first minimum, and on the marked sample emits one result: the pulse height
// (baseline minus minimum, where the baseline is the first window's mean if the minimum comes
// later than late_peak_ns, else the fourth window's mean, truncated), the dark flag
// (height strictly above threshold_counts), the peak index and wrapping dark and event totals.
// Unmarked samples give no result. One sample is taken every cycle, except while a marked sample
// waits in the input register for the divide stage; the rate is set by the window and minimum
// update, which is a single register stage. After its marked sample is accepted into the input
// register, a result passes accumulate, reciprocal-multiply divide and peak timing, then height
// and threshold compare, each ending in a register, and the output register lets new samples
// flow while a result waits. Registers may be written only while no waveform is in flight.
module pmt_dark_pulse_discriminator #(
  parameter int unsigned MAX_SAMPLES = pmtdpd_pkg::MAX_SAMPLES_DEF,
  parameter int unsigned WINDOW_LEN  = pmtdpd_pkg::WINDOW_LEN_DEF
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  // Sample channel.
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  logic [pmtdpd_pkg::ADC_BITS-1:0]       sample_i,
  input  logic                                  last_sample_i,
  // Result channel.
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output logic signed [pmtdpd_pkg::HEIGHT_W-1:0] pulse_height_o,
  output logic                                  is_dark_pulse_o,
  output logic [pmtdpd_pkg::PEAK_W-1:0]         peak_index_o,
  output logic [pmtdpd_pkg::COUNT_W-1:0]        dark_total_o,
  output logic [pmtdpd_pkg::COUNT_W-1:0]        event_total_o,
  // Configuration write port.
  input  logic                                  cfg_we_i,
  input  logic [pmtdpd_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [pmtdpd_pkg::CFG_DATA_W-1:0]     cfg_data_i
);

  import pmtdpd_pkg::*;

  // Derived sizes.
  localparam int unsigned POS_W  = $clog2(MAX_SAMPLES);
  localparam int unsigned WCNT_W = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
  localparam int unsigned WIDX_W = $clog2(NUM_WIN + 1);
  localparam int unsigned WSEL_W = $clog2(NUM_WIN);
  // When the position saturates inside the windows, one window keeps summing and wraps.
  localparam bit          SUM_WRAPS = (MAX_SAMPLES - 1) < (NUM_WIN * WINDOW_LEN);
  localparam longint unsigned SUM_MAX = SUM_WRAPS ? 64'hFFFF_FFFF
                                                  : longint'(WINDOW_LEN) * ADC_MAX;
  localparam int unsigned SUM_W   = $clog2(SUM_MAX + 1);
  localparam longint unsigned QUO_MAX = SUM_MAX / WINDOW_LEN;
  localparam int unsigned QUO_W   = $clog2(QUO_MAX + 1);
  // Reciprocal divide: exact for every sum below 2**SUM_W, no correction needed.
  localparam int unsigned DIV_SHIFT = SUM_W + $clog2(WINDOW_LEN);
  localparam int unsigned RECIP_W   = SUM_W + 1;
  localparam longint unsigned RECIP = ((64'd1 << DIV_SHIFT) / WINDOW_LEN) + 1;
  localparam logic [RECIP_W-1:0] RECIP_C = RECIP_W'(RECIP);
  localparam int unsigned PROD_W    = SUM_W + RECIP_W;
  localparam int unsigned PEAK_NS_W = POS_W + NSPS_W;
  localparam int unsigned HT_W      = QUO_W + 1;

  localparam logic [POS_W-1:0]  POS_LAST  = POS_W'(MAX_SAMPLES - 1);
  localparam logic [WCNT_W-1:0] WCNT_LAST = WCNT_W'(WINDOW_LEN - 1);
  localparam logic [WIDX_W-1:0] WIDX_END  = WIDX_W'(NUM_WIN);

  // Configuration registers.
  logic [THR_W-1:0]  threshold_q;
  logic [NSPS_W-1:0] nsps_q;
  logic [LATE_W-1:0] late_q;

  // Handshake and stage control.
  logic ready_in, ready_b, ready_c, ready_out;
  logic fire_a, load_b, load_c, load_out;

  // Input register.
  logic                in_valid_q;
  logic [ADC_BITS-1:0] in_sample_q;
  logic                in_last_q;

  // Waveform state.
  logic [POS_W-1:0]    pos_q, pos_d;
  logic [WCNT_W-1:0]   wcnt_q, wcnt_d;
  logic [WIDX_W-1:0]   widx_q, widx_d;
  logic [SUM_W-1:0]    sums_q [NUM_WIN];
  logic [SUM_W-1:0]    sums_d [NUM_WIN];
  logic [ADC_BITS-1:0] min_q, min_d;
  logic [POS_W-1:0]    min_pos_q, min_pos_d;

  // Divide and timing stage.
  logic                b_valid_q;
  logic [SUM_W-1:0]    b_sum0_q, b_sum3_q;
  logic [ADC_BITS-1:0] b_min_q;
  logic [POS_W-1:0]    b_pos_q;
  logic [PROD_W-1:0]   prod0, prod3;
  logic [PEAK_NS_W-1:0] peak_ns;
  logic                late_peak;

  // Height stage.
  logic                c_valid_q;
  logic [QUO_W-1:0]    c_quo0_q, c_quo3_q;
  logic                c_late_q;
  logic [ADC_BITS-1:0] c_min_q;
  logic [POS_W-1:0]    c_pos_q;
  logic [QUO_W-1:0]    baseline;
  logic signed [HT_W-1:0] height;
  logic                dark;

  // Totals and output register.
  logic [COUNT_W-1:0]  dark_count_q, event_count_q;
  logic                out_valid_q;

  // Stage advance: each stage moves when the one after it is empty or moving.
  always_comb begin
    ready_out = !out_valid_q || !out_stall_i;
    load_out  = c_valid_q && ready_out;
    ready_c   = !c_valid_q || ready_out;
    load_c    = b_valid_q && ready_c;
    ready_b   = !b_valid_q || ready_c;
    fire_a    = in_valid_q && (!in_last_q || ready_b);
    load_b    = fire_a && in_last_q;
    ready_in  = !in_valid_q || !in_last_q || ready_b;
  end

  assign in_stall_o = !ready_in;

  // Configuration writes; unknown indexes are dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      threshold_q <= THRESHOLD_RST;
      nsps_q      <= NSPS_RST;
      late_q      <= LATE_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_THRESHOLD:     threshold_q <= cfg_data_i[THR_W-1:0];
        CFG_NS_PER_SAMPLE: nsps_q      <= cfg_data_i[NSPS_W-1:0];
        CFG_LATE_PEAK:     late_q      <= cfg_data_i[LATE_W-1:0];
        default: ;
      endcase
    end
  end

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (ready_in) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && ready_in) begin
      in_sample_q <= sample_i;
      in_last_q   <= last_sample_i;
    end
  end

  // Per-sample update of window sums, minimum and position.
  always_comb begin
    pos_d     = pos_q;
    wcnt_d    = wcnt_q;
    widx_d    = widx_q;
    min_d     = min_q;
    min_pos_d = min_pos_q;
    for (int i = 0; i < NUM_WIN; i++) begin
      sums_d[i] = sums_q[i];
    end
    if (widx_q < WIDX_END) begin
      sums_d[widx_q[WSEL_W-1:0]] = sums_q[widx_q[WSEL_W-1:0]]
                                   + SUM_W'(in_sample_q);
    end
    if (in_sample_q < min_q) begin
      min_d     = in_sample_q;
      min_pos_d = pos_q;
    end
    // The window counters follow the position, so they freeze with it.
    if (pos_q < POS_LAST) begin
      pos_d = pos_q + POS_W'(1);
      if (wcnt_q == WCNT_LAST) begin
        wcnt_d = '0;
        if (widx_q < WIDX_END) begin
          widx_d = widx_q + WIDX_W'(1);
        end
      end else begin
        wcnt_d = wcnt_q + WCNT_W'(1);
      end
    end
  end

  // Waveform state; the final sample hands it to the next stage and clears it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q     <= '0;
      wcnt_q    <= '0;
      widx_q    <= '0;
      min_q     <= {ADC_BITS{1'b1}};
      min_pos_q <= '0;
      for (int i = 0; i < NUM_WIN; i++) begin
        sums_q[i] <= '0;
      end
    end else if (fire_a) begin
      if (in_last_q) begin
        pos_q     <= '0;
        wcnt_q    <= '0;
        widx_q    <= '0;
        min_q     <= {ADC_BITS{1'b1}};
        min_pos_q <= '0;
        for (int i = 0; i < NUM_WIN; i++) begin
          sums_q[i] <= '0;
        end
      end else begin
        pos_q     <= pos_d;
        wcnt_q    <= wcnt_d;
        widx_q    <= widx_d;
        min_q     <= min_d;
        min_pos_q <= min_pos_d;
        for (int i = 0; i < NUM_WIN; i++) begin
          sums_q[i] <= sums_d[i];
        end
      end
    end
  end

  // Divide stage registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q <= 1'b0;
    end else if (ready_b) begin
      b_valid_q <= load_b;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_b) begin
      b_sum0_q <= sums_d[0];
      b_sum3_q <= sums_d[NUM_WIN-1];
      b_min_q  <= min_d;
      b_pos_q  <= min_pos_d;
    end
  end

  // Both candidate baselines by reciprocal multiply, and the peak time in parallel.
  always_comb begin
    prod0     = {{RECIP_W{1'b0}}, b_sum0_q} * {{SUM_W{1'b0}}, RECIP_C};
    prod3     = {{RECIP_W{1'b0}}, b_sum3_q} * {{SUM_W{1'b0}}, RECIP_C};
    peak_ns   = {{NSPS_W{1'b0}}, b_pos_q} * {{POS_W{1'b0}}, nsps_q};
    late_peak = peak_ns > {{(PEAK_NS_W-LATE_W){1'b0}}, late_q};
  end

  // Height stage registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_valid_q <= 1'b0;
    end else if (ready_c) begin
      c_valid_q <= load_c;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_c) begin
      c_quo0_q <= prod0[DIV_SHIFT +: QUO_W];
      c_quo3_q <= prod3[DIV_SHIFT +: QUO_W];
      c_late_q <= late_peak;
      c_min_q  <= b_min_q;
      c_pos_q  <= b_pos_q;
    end
  end

  // Baseline choice, height and threshold compare; negative heights are never dark.
  always_comb begin
    baseline = c_late_q ? c_quo0_q : c_quo3_q;
    height   = $signed({1'b0, baseline})
               - $signed({{(HT_W-ADC_BITS){1'b0}}, c_min_q});
    dark     = height > $signed({{(HT_W-THR_W){1'b0}}, threshold_q});
  end

  // Running totals and output valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q   <= 1'b0;
      dark_count_q  <= '0;
      event_count_q <= '0;
    end else begin
      if (ready_out) begin
        out_valid_q <= c_valid_q;
      end
      if (load_out) begin
        dark_count_q  <= dark_count_q + COUNT_W'(dark);
        event_count_q <= event_count_q + COUNT_W'(1);
      end
    end
  end

  // Result payload.
  always_ff @(posedge clk_i) begin
    if (load_out) begin
      pulse_height_o  <= height[HEIGHT_W-1:0];
      is_dark_pulse_o <= dark;
      peak_index_o    <= c_pos_q[PEAK_W-1:0];
      dark_total_o    <= dark_count_q + COUNT_W'(dark);
      event_total_o   <= event_count_q + COUNT_W'(1);
    end
  end

  assign out_valid_o = out_valid_q;

`ifndef SYNTH
  // The waveform state is back at its cleared values after a final sample.
  a_clear_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire_a && in_last_q) |=> (pos_q == '0 && widx_q == '0 && min_q == {ADC_BITS{1'b1}}))
    else $error("waveform state not cleared after final sample");

  // The dark count steps exactly when the delivered result is flagged dark.
  a_dark_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_out |=> (dark_count_q - $past(dark_count_q)) == COUNT_W'(is_dark_pulse_o))
    else $error("dark count step disagrees with dark flag");

  // A pending result carries the current totals.
  a_totals_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (event_total_o == event_count_q && dark_total_o == dark_count_q))
    else $error("result totals differ from running counts");
`endif

endmodule

>>> bench/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import pmtdpd_pkg::*;

  localparam int unsigned WATCHDOG_LIMIT = 5000;
  localparam int unsigned DRAIN_CYCLES   = 12;
  localparam int unsigned NUM_PHASES     = 8;
  localparam int unsigned PHASE_ITEMS    = 175;
  localparam int unsigned PHASE_WAVES    = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_INDEX = 2'd3;

  // Register settings per phase; a negative entry means a random value.
  localparam int PHASE_THRESHOLD[NUM_PHASES] = '{10, 0, 16383, 40, 200, -1, 5, 100};
  localparam int PHASE_NSPS[NUM_PHASES]      = '{2, 1, 64, 128, 127, -1, 3, 2};
  localparam int PHASE_LATE[NUM_PHASES]      = '{60, 0, 1023, 'h3C3C, 500, -1, 90, 60};

  typedef struct {
    logic signed [HEIGHT_W-1:0] height;
    logic                       dark;
    logic [PEAK_W-1:0]          peak;
    logic [COUNT_W-1:0]         dark_total;
    logic [COUNT_W-1:0]         event_total;
  } pulse_result_t;

  // Tracks the waveform state and the registers, and holds the pulse results still due.
  class pulse_checker;
    logic [THR_W-1:0]   threshold;
    logic [NSPS_W-1:0]  ns_per_sample;
    logic [LATE_W-1:0]  late_peak_ns;
    int unsigned        position;
    int unsigned        window_sum[NUM_WIN];
    logic [ADC_BITS-1:0] min_sample;
    int unsigned        min_index;
    logic [COUNT_W-1:0] dark_count;
    logic [COUNT_W-1:0] event_count;
    pulse_result_t      expected_pulses[$];
    int                 errors;

    function new();
      threshold     = THRESHOLD_RST;
      ns_per_sample = NSPS_RST;
      late_peak_ns  = LATE_RST;
      dark_count    = '0;
      event_count   = '0;
      errors        = 0;
      clear_waveform();
    endfunction

    function void clear_waveform();
      position = 0;
      foreach (window_sum[i]) window_sum[i] = 0;
      min_sample = ADC_BITS'(ADC_MAX);
      min_index  = 0;
    endfunction

    // Registers keep only their low bits; unknown indexes are dropped.
    function void write_register(logic [CFG_IDX_W-1:0] index, logic [CFG_DATA_W-1:0] data);
      case (index)
        CFG_THRESHOLD:     threshold     = data[THR_W-1:0];
        CFG_NS_PER_SAMPLE: ns_per_sample = data[NSPS_W-1:0];
        CFG_LATE_PEAK:     late_peak_ns  = data[LATE_W-1:0];
        default: ;
      endcase
    endfunction

    // Accumulates one sample and, on the marked one, works out the pulse result.
    function void note_sample(logic [ADC_BITS-1:0] s, logic last);
      int unsigned   win;
      int unsigned   peak_ns;
      int unsigned   baseline;
      int            height;
      pulse_result_t r;
      win = position / WINDOW_LEN_DEF;
      if (win < NUM_WIN) window_sum[win] += s;
      // Ties keep the earliest index.
      if (s < min_sample) begin
        min_sample = s;
        min_index  = position;
      end
      if (position < MAX_SAMPLES_DEF - 1) position++;
      if (last) begin
        peak_ns = min_index * ns_per_sample;
        if (peak_ns > late_peak_ns) begin
          baseline = window_sum[0] / WINDOW_LEN_DEF;
        end else begin
          baseline = window_sum[NUM_WIN-1] / WINDOW_LEN_DEF;
        end
        height = int'(baseline) - int'(min_sample);
        r.dark = height > int'(threshold);
        if (r.dark) dark_count++;
        event_count++;
        r.height      = height[HEIGHT_W-1:0];
        r.peak        = min_index[PEAK_W-1:0];
        r.dark_total  = dark_count;
        r.event_total = event_count;
        expected_pulses.push_back(r);
        clear_waveform();
      end
    endfunction

    function void check_pulse(logic signed [HEIGHT_W-1:0] height, logic dark,
                              logic [PEAK_W-1:0] peak, logic [COUNT_W-1:0] dark_total,
                              logic [COUNT_W-1:0] event_total);
      pulse_result_t e;
      if (expected_pulses.size() == 0) begin
        $error("unexpected pulse result with pulse_height %0d", height);
        errors++;
        return;
      end
      e = expected_pulses.pop_front();
      if (height !== e.height) begin
        $error("pulse_height: expected %0d, got %0d", e.height, height);
        errors++;
      end
      if (dark !== e.dark) begin
        $error("is_dark_pulse: expected %0d, got %0d", e.dark, dark);
        errors++;
      end
      if (peak !== e.peak) begin
        $error("peak_index: expected %0d, got %0d", e.peak, peak);
        errors++;
      end
      if (dark_total !== e.dark_total) begin
        $error("dark_total: expected %0d, got %0d", e.dark_total, dark_total);
        errors++;
      end
      if (event_total !== e.event_total) begin
        $error("event_total: expected %0d, got %0d", e.event_total, event_total);
        errors++;
      end
    endfunction

    function int pending();
      return expected_pulses.size();
    endfunction
  endclass

  logic                        clk_i         = 1'b0;
  logic                        rst_ni        = 1'b0;
  logic                        in_valid_i    = 1'b0;
  logic                        in_stall_o;
  logic [ADC_BITS-1:0]         sample_i      = '0;
  logic                        last_sample_i = 1'b0;
  logic                        out_valid_o;
  logic                        out_stall_i   = 1'b0;
  logic signed [HEIGHT_W-1:0]  pulse_height_o;
  logic                        is_dark_pulse_o;
  logic [PEAK_W-1:0]           peak_index_o;
  logic [COUNT_W-1:0]          dark_total_o;
  logic [COUNT_W-1:0]          event_total_o;
  logic                        cfg_we_i      = 1'b0;
  logic [CFG_IDX_W-1:0]        cfg_index_i   = '0;
  logic [CFG_DATA_W-1:0]       cfg_data_i    = '0;

  pulse_checker pulses = new();
  int           idle_pct = 0;
  int           stall_pct = 0;
  int           sent_items = 0;
  int           sent_waves = 0;
  int unsigned  quiet_cycles = 0;

  pmt_dark_pulse_discriminator DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .sample_i        (sample_i),
    .last_sample_i   (last_sample_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .pulse_height_o  (pulse_height_o),
    .is_dark_pulse_o (is_dark_pulse_o),
    .peak_index_o    (peak_index_o),
    .dark_total_o    (dark_total_o),
    .event_total_o   (event_total_o),
    .cfg_we_i        (cfg_we_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // The result side stalls at random.
  always @(negedge clk_i) begin
    out_stall_i <= ($urandom_range(99, 0) < stall_pct);
  end

  // Every accepted result is checked against the oldest prediction.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      pulses.check_pulse(pulse_height_o, is_dark_pulse_o, peak_index_o, dark_total_o,
                         event_total_o);
    end
  end

  // The run ends if neither channel moves a request for too long.
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
      $display("testbench NOT OK");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Presents one sample, with random idle cycles first, and holds it until it is taken.
  task automatic send_sample(input logic [ADC_BITS-1:0] s, input logic last);
    while ($urandom_range(99, 0) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i    <= 1'b1;
    sample_i      <= s;
    last_sample_i <= last;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    pulses.note_sample(s, last);
    sent_items++;
    @(negedge clk_i);
  endtask

  // Sends a waveform: mostly a noisy baseline with one dip, else pure noise or a flat line.
  task automatic send_waveform(input int len);
    int style;
    int base;
    int spread;
    int dip_at;
    int dip_depth;
    int dip_width;
    int value;
    style     = $urandom_range(99, 0);
    base      = $urandom_range(ADC_MAX, 0);
    spread    = $urandom_range(12, 0);
    dip_at    = $urandom_range(len - 1, 0);
    dip_depth = $urandom_range(base, 0);
    dip_width = $urandom_range(4, 1);
    for (int i = 0; i < len; i++) begin
      if (style < 65) begin
        value = base + int'($urandom_range(2 * spread, 0)) - spread;
        if (i >= dip_at && i < dip_at + dip_width) value -= dip_depth;
      end else if (style < 85) begin
        value = $urandom_range(ADC_MAX, 0);
      end else begin
        value = base;
      end
      if (value < 0) value = 0;
      if (value > int'(ADC_MAX)) value = ADC_MAX;
      send_sample(value[ADC_BITS-1:0], i == len - 1);
    end
    sent_waves++;
  endtask

  // Short waveforms are common; full, past-the-windows and overlong ones are mixed in.
  function automatic int random_length();
    int pick;
    pick = $urandom_range(99, 0);
    if (pick < 45) return $urandom_range(30, 1);
    if (pick < 55) return $urandom_range(94, 31);
    if (pick < 80) return $urandom_range(110, 95);
    if (pick < 90) return $urandom_range(128, 111);
    return $urandom_range(150, 129);
  endfunction

  // Waits until every result has come out, then lets the pipeline settle.
  task automatic wait_idle();
    while (pulses.pending() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  task automatic program_register(input logic [CFG_IDX_W-1:0] index,
                                  input logic [CFG_DATA_W-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= index;
    cfg_data_i  <= data;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    pulses.write_register(index, data);
  endtask

  initial begin
    int phase_items;
    int phase_waves;
    int thr;
    int nsps;
    int late;
    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Single-sample waveforms: empty fourth window, zero and full-scale minimum.
    send_sample('0, 1'b1);
    send_sample(ADC_BITS'(ADC_MAX), 1'b1);
    // A flat waveform, where every sample ties for the minimum.
    for (int i = 0; i < 3; i++) send_sample(ADC_BITS'(500), i == 2);
    // A short waveform with a repeated minimum, giving a negative height.
    send_sample(ADC_BITS'(ADC_MAX), 1'b0);
    send_sample(ADC_BITS'(ADC_MAX), 1'b0);
    send_sample(ADC_BITS'(7), 1'b0);
    send_sample(ADC_BITS'(7), 1'b0);
    send_sample(ADC_BITS'('h2AAA), 1'b1);
    // Alternating bit patterns.
    send_sample(ADC_BITS'('h1555), 1'b0);
    send_sample(ADC_BITS'('h2AAA), 1'b0);
    send_sample(ADC_BITS'('h1555), 1'b1);

    // Random phases, each with its own register setting and idling pattern.
    for (int p = 0; p < NUM_PHASES; p++) begin
      in_valid_i <= 1'b0;
      wait_idle();
      if (p != 0) begin
        thr  = (PHASE_THRESHOLD[p] < 0) ? $urandom_range(300, 0) : PHASE_THRESHOLD[p];
        nsps = (PHASE_NSPS[p] < 0) ? $urandom_range(ADC_MAX, 0) : PHASE_NSPS[p];
        late = (PHASE_LATE[p] < 0) ? $urandom_range(ADC_MAX, 0) : PHASE_LATE[p];
        program_register(CFG_THRESHOLD, thr[CFG_DATA_W-1:0]);
        program_register(CFG_NS_PER_SAMPLE, nsps[CFG_DATA_W-1:0]);
        program_register(CFG_LATE_PEAK, late[CFG_DATA_W-1:0]);
        program_register(CFG_UNUSED_INDEX, CFG_DATA_W'($urandom_range(ADC_MAX, 0)));
      end
      case (p % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 87; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 87; end
        default: begin idle_pct = 32; stall_pct = 32; end
      endcase
      phase_items = sent_items;
      phase_waves = sent_waves;
      while (sent_items - phase_items < PHASE_ITEMS || sent_waves - phase_waves < PHASE_WAVES)
        send_waveform(random_length());
    end

    in_valid_i <= 1'b0;
    wait_idle();
    if (pulses.errors == 0 && pulses.pending() == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule
